FILE: design/tmdq_pkg.sv
// Package for the first-match dequeue queue: actions, word types, entry type.
// Used by tmdq_cell and tag_match_dequeue_fifo_unit; depends on nothing.
`default_nettype none
package tmdq_pkg;

  localparam int QueueDepthDef = 16;
  localparam int IdW   = 16;
  localparam int PrefW = 3;
  localparam int CountW = 5;

  typedef enum logic [1:0] {
    ACT_ENQ      = 2'd0,
    ACT_DEQ_HEAD = 2'd1,
    ACT_DEQ_MTCH = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [IdW-1:0]     patient_id;
    logic [PrefW-1:0]   doctor_pref;
    logic [PrefW-1:0]   free_server;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [IdW-1:0]     out_id;
    logic [PrefW-1:0]   out_pref;
    logic [CountW-1:0]  count;
    logic               rejected;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [PrefW-1:0]   pref;
  } entry_t;

endpackage
`default_nettype wire

FILE: design/tmdq_cell.sv
// One slot of the queue: holds an entry, compares it, passes the hit and the
// selected entry down the chain and takes its right neighbour on removal.
// Depends on tmdq_pkg.
`default_nettype none
module tmdq_cell
  import tmdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int IDX = 0,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic            clk,
  input  wire logic            load,
  input  wire in_t             req,
  input  wire logic [CntW-1:0] count,
  input  wire logic            hit_in,
  input  wire entry_t          sel_in,
  input  wire entry_t          nbr_in,
  output logic                 hit_out,
  output entry_t               sel_out,
  output entry_t               ent_out
);

  localparam logic [CntW-1:0] MyIdx = CntW'(IDX);

  entry_t ent_r, ent_nxt;
  logic   occupied, match, is_deq;

  always_comb begin
    occupied = (MyIdx < count);
    is_deq   = 1'b0;
    match    = 1'b0;
    case (req.action)
      ACT_DEQ_HEAD: begin
        is_deq = 1'b1;
        match  = occupied;
      end
      ACT_DEQ_MTCH: begin
        is_deq = 1'b1;
        match  = occupied && ((ent_r.pref == '0) || (ent_r.pref == req.free_server));
      end
      default: begin
        is_deq = 1'b0;
        match  = 1'b0;
      end
    endcase
  end

  assign hit_out = hit_in | match;
  // first hit in the chain claims the output word
  assign sel_out = (match && !hit_in) ? ent_r : sel_in;
  assign ent_out = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (is_deq && hit_out) begin
      ent_nxt = nbr_in;
    end else if ((req.action == ACT_ENQ) && (count == MyIdx)) begin
      ent_nxt.id   = req.patient_id;
      ent_nxt.pref = req.doctor_pref;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= ent_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/tag_match_dequeue_fifo_unit.sv
// Queue with head and first-match dequeue, built as a chain of tmdq_cell slots.
// The result word is registered: it appears on out_data with out_strobe in the
// cycle after the accepting cycle. Throughput: one request per cycle; busy stays low,
// the compare and shift in every slot finish within the accepting cycle.
// Reset (rst_n, synchronous) empties the queue; slot contents are not cleared.
// The receiver cannot stall. Depends on tmdq_pkg and tmdq_cell.
`default_nettype none
module tag_match_dequeue_fifo_unit
  import tmdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_strobe,
  output out_t      out_data
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);

  logic [CntW-1:0] count_r, count_nxt;
  logic            strobe_r;
  out_t            out_r, out_nxt;
  logic            accept;

  logic   hit [QUEUE_DEPTH+1];
  entry_t sel [QUEUE_DEPTH+1];
  entry_t ent [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign accept = start;

  assign hit[0] = 1'b0;
  assign sel[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nbr;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr = ent[i];
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    tmdq_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk     (clk),
      .load    (accept),
      .req     (in_data),
      .count   (count_r),
      .hit_in  (hit[i]),
      .sel_in  (sel[i]),
      .nbr_in  (nbr),
      .hit_out (hit[i+1]),
      .sel_out (sel[i+1]),
      .ent_out (ent[i])
    );
  end

  always_comb begin
    count_nxt        = count_r;
    out_nxt          = '0;
    out_nxt.found    = hit[QUEUE_DEPTH];
    out_nxt.out_id   = sel[QUEUE_DEPTH].id;
    out_nxt.out_pref = sel[QUEUE_DEPTH].pref;
    case (in_data.action)
      ACT_ENQ: begin
        if (count_r == Full) begin
          out_nxt.rejected = 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_DEQ_HEAD, ACT_DEQ_MTCH: begin
        if (hit[QUEUE_DEPTH]) begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_nxt.count = CountW'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // hold the result word for its single strobe cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule
`default_nettype wire

FILE: bench/tmdq_queue_checker.sv
// Checker for tag_match_dequeue_fifo_unit: predicts each result word from the accepted
// request words, compares field by field and counts failures. Depends on tmdq_pkg.
module tmdq_queue_checker
  import tmdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_strobe,
  input  out_t out_data,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [IdW-1:0]   slot_id   [QUEUE_DEPTH];
  logic [PrefW-1:0] slot_pref [QUEUE_DEPTH];
  int               occupancy;
  out_t             awaited_results [$];
  int               shown;

  // Apply one request to the shadow queue and return the word it should produce.
  function automatic out_t predict_queue_step(in_t w);
    out_t r;
    int   hit;
    r   = '0;
    hit = -1;
    case (w.action)
      ACT_ENQ: begin
        if (occupancy >= QUEUE_DEPTH) begin
          r.rejected = 1'b1;
        end else begin
          slot_id[occupancy]   = w.patient_id;
          slot_pref[occupancy] = w.doctor_pref;
          occupancy++;
        end
      end
      ACT_DEQ_HEAD: begin
        if (occupancy > 0) hit = 0;
      end
      ACT_DEQ_MTCH: begin
        for (int i = 0; i < occupancy; i++) begin
          if (hit < 0 && (slot_pref[i] == '0 || slot_pref[i] == w.free_server)) hit = i;
        end
      end
      default: ;
    endcase
    if (hit >= 0) begin
      r.found    = 1'b1;
      r.out_id   = slot_id[hit];
      r.out_pref = slot_pref[hit];
      // close the gap, keeping arrival order
      for (int i = hit; i + 1 < occupancy; i++) begin
        slot_id[i]   = slot_id[i+1];
        slot_pref[i] = slot_pref[i+1];
      end
      occupancy--;
    end
    r.count = occupancy[CountW-1:0];
    return r;
  endfunction

  function automatic void report(string what, out_t exp_w, out_t got_w);
    fail_count++;
    if (shown < 10) begin
      shown++;
      $write("%0t: %s: expected found=%0d id=%h pref=%0d count=%0d rej=%0d, ",
             $time, what, exp_w.found, exp_w.out_id, exp_w.out_pref, exp_w.count,
             exp_w.rejected);
      $display("got found=%0d id=%h pref=%0d count=%0d rej=%0d",
               got_w.found, got_w.out_id, got_w.out_pref, got_w.count,
               got_w.rejected);
    end
  endfunction

  initial begin
    fail_count = 0;
    shown      = 0;
    occupancy  = 0;
  end

  assign pending = awaited_results.size();

  always @(posedge clk) begin
    out_t exp_w;
    if (!rst_n) begin
      occupancy = 0;
      awaited_results.delete();
    end else begin
      // compare before pushing: the strobe seen now answers a word accepted earlier, not the one accepted at this edge
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          report("unexpected result word", '0, out_data);
        end else begin
          exp_w = awaited_results.pop_front();
          if (out_data.found !== exp_w.found || out_data.out_id !== exp_w.out_id ||
              out_data.out_pref !== exp_w.out_pref || out_data.count !== exp_w.count ||
              out_data.rejected !== exp_w.rejected)
            report("result mismatch", exp_w, out_data);
        end
      end
      if (start && !busy) awaited_results.push_back(predict_queue_step(in_data));
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the bench for tag_match_dequeue_fifo_unit: clock, reset, directed and random
// request words, verdict. Depends on tmdq_pkg, tag_match_dequeue_fifo_unit and tmdq_queue_checker.
module testbench;
  import tmdq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 1000;
  localparam int CycleLimit  = 400000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_strobe;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   cycle_cnt;

  tag_match_dequeue_fifo_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  tmdq_queue_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic in_t make_word(action_t act, logic [IdW-1:0] id,
                                    logic [PrefW-1:0] pref, logic [PrefW-1:0] server);
    in_t w;
    w.action      = act;
    w.patient_id  = id;
    w.doctor_pref = pref;
    w.free_server = server;
    return w;
  endfunction

  // Hold start and the word until the block takes it.
  task automatic issue(in_t w);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 9);
    if (burst || r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    bit               filling;
    bit               burst;
    int               phase_left;
    int               r;
    action_t          act;
    logic [PrefW-1:0] pref;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: both dequeues find nothing, the spare action only reports count
    issue(make_word(ACT_DEQ_HEAD, 16'h0, 3'd0, 3'd1));
    issue(make_word(ACT_DEQ_MTCH, 16'h0, 3'd0, 3'd7));
    idle(pick_gap(1'b0));
    issue(make_word(ACT_NONE, 16'hFFFF, 3'd7, 3'd7));
    // fill with non-zero preferences, extreme ids first
    issue(make_word(ACT_ENQ, 16'hFFFF, 3'd7, 3'd0));
    issue(make_word(ACT_ENQ, 16'h0000, 3'd1, 3'd0));
    for (int i = 2; i < QueueDepthDef; i++) begin
      issue(make_word(ACT_ENQ, 16'($urandom), 3'(1 + i % 7), 3'($urandom)));
      idle(pick_gap(1'b0));
    end
    // full: refuse the word
    issue(make_word(ACT_ENQ, 16'h1234, 3'd0, 3'd0));
    // free server zero: no entry has preference zero, so nothing matches
    issue(make_word(ACT_DEQ_MTCH, 16'h0, 3'd0, 3'd0));
    issue(make_word(ACT_DEQ_MTCH, 16'h0, 3'd0, 3'd7));
    issue(make_word(ACT_DEQ_HEAD, 16'h0, 3'd0, 3'd0));
    issue(make_word(ACT_NONE, 16'h0, 3'd0, 3'd0));
    issue(make_word(ACT_ENQ, 16'hA5A5, 3'd0, 3'd0));
    issue(make_word(ACT_DEQ_MTCH, 16'h0, 3'd0, 3'd5));

    // random: alternate filling and draining phases so the queue swings end to end
    filling    = 1'b1;
    burst      = 1'b0;
    phase_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(10, 50);
        burst      = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < (filling ? 65 : 25))      act = ACT_ENQ;
      else if (r < (filling ? 78 : 55)) act = ACT_DEQ_HEAD;
      else if (r < 95)                  act = ACT_DEQ_MTCH;
      else                              act = ACT_NONE;
      pref = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
      issue(make_word(act, 16'($urandom), pref, 3'($urandom_range(0, 7))));
      idle(pick_gap(burst));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
